>>> hw/rtl/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg
// Types, constants and calendar helpers shared by the date adder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gda_pkg;

  // Width of the signed amount operand.
  localparam int AMOUNT_BITS = 16;
  localparam int YEAR_BITS   = 16;

  // Internal year keeps headroom so that leap years follow the true year.
  localparam int YW = ((AMOUNT_BITS > YEAR_BITS) ? AMOUNT_BITS : YEAR_BITS) + 2;
  // Day accumulator must hold both the amount and the 400-year day count.
  localparam int DW = (AMOUNT_BITS + 2 > 19) ? AMOUNT_BITS + 2 : 19;
  // Remainder width of the divider (0 to 399).
  localparam int REM_W = 9;

  // The divider sees a magnitude below 2^(YW-1). Dividing by 12 is a shift by
  // two and a division by 3, dividing by 400 a shift by four and a division by
  // 25; both divisions use a rounded-up reciprocal that is exact over the
  // whole operand range.
  localparam int Q3_W  = YW - 3;
  localparam int K3    = Q3_W + 2;
  localparam int M3_W  = K3 - 1;
  localparam int P3_W  = Q3_W + M3_W;
  localparam int Q25_W = YW - 5;
  localparam int K25   = Q25_W + 5;
  localparam int M25_W = K25 - 4;
  localparam int P25_W = Q25_W + M25_W;

  localparam logic [M3_W-1:0]  RECIP_3  = M3_W'(((longint'(1) << K3) + 2) / 3);
  localparam logic [M25_W-1:0] RECIP_25 = M25_W'(((longint'(1) << K25) + 24) / 25);
  localparam logic [REM_W-1:0] DIVISOR_12  = REM_W'(12);
  localparam logic [REM_W-1:0] DIVISOR_400 = REM_W'(400);

  localparam logic signed [DW-1:0] DAYS_400   = DW'(146097);
  localparam logic signed [DW-1:0] CENT_LIMIT = DW'(146097 + 31);
  localparam logic signed [YW-1:0] YEARS_400  = YW'(400);
  localparam logic [REM_W-1:0]     YMOD_MAX   = REM_W'(399);

  localparam logic [3:0] MONTH_FIRST = 4'd1;
  localparam logic [3:0] MONTH_LAST  = 4'd12;
  localparam logic [4:0] FEB_LEAP    = 5'd29;

  localparam logic [4:0] MONTH_LEN [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    CMD_DAYS   = 2'd0,
    CMD_MONTHS = 2'd1,
    CMD_YEARS  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic {
    DIV_BY_12  = 1'b0,
    DIV_BY_400 = 1'b1
  } div_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QDIV,
    S_MODGO,
    S_MOD,
    S_CENT,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     start;
    div_sel_t sel;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [YW-1:0]   quo;
    logic [REM_W-1:0]       rem;
  } div_rsp_t;

  // ymod is the year taken modulo 400 (0 to 399), ylow the year's two low bits.
  function automatic logic is_leap(input logic [REM_W-1:0] ymod, input logic [1:0] ylow);
    logic century;
    century = ymod inside {REM_W'(0), REM_W'(100), REM_W'(200), REM_W'(300)};
    return ((ylow == 2'd0) && !century) || (ymod == REM_W'(0));
  endfunction

  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m == 4'd2 && leap) begin
      len = FEB_LEAP;
    end else if (m < MONTH_FIRST || m > MONTH_LAST) begin
      len = 5'd31;
    end else begin
      len = MONTH_LEN[m];
    end
    return len;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gregorian_date_adder.sv
// ----------------------------------------------------------------------------
// gregorian_date_adder
// Adds a signed number of days, months or years to a Gregorian date.
// ----------------------------------------------------------------------------
//
// Channel   Handshake      Fields
// command   start / busy   command, year_in, month_in, day_in, amount
// result    done           year_out, month_out, day_out, year_overflow
//
// A word is taken at a clock edge with start high and busy low. Add days
// divides the year by 400, skips whole 400-year cycles and then walks the
// day accumulator month by month, and the month walk takes the longest.
// Add months divides by 12 and then by 400 and add years only by 400, both
// through the three-stage divider. A zero amount or the unused command goes
// straight to the result. Busy falls as the result word is shown, so the
// next word can be taken at the edge that takes the result. The result word
// is shown for one cycle with done high and the receiver cannot stall it.
// Reset is synchronous and returns the sequencer to idle at once.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_adder (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     start,
  input  wire logic [1:0]                               command,
  input  wire logic signed [15:0]                       year_in,
  input  wire logic [3:0]                               month_in,
  input  wire logic [4:0]                               day_in,
  input  wire logic signed [gda_pkg::AMOUNT_BITS-1:0]   amount,
  output      logic                                     busy,
  output      logic                                     done,
  output      logic signed [15:0]                       year_out,
  output      logic [3:0]                               month_out,
  output      logic [4:0]                               day_out,
  output      logic                                     year_overflow
);

  localparam int YW = gda_pkg::YW;
  localparam int DW = gda_pkg::DW;
  localparam int AB = gda_pkg::AMOUNT_BITS;
  localparam int RW = gda_pkg::REM_W;

  gda_pkg::state_t state, state_next;
  gda_pkg::cmd_t   cmd, cmd_next;
  logic            neg, neg_next;
  logic            clamp, clamp_next;
  logic signed [YW-1:0] year, year_next;
  logic [3:0]           month, month_next;
  logic signed [DW-1:0] day, day_next;
  logic [RW-1:0]        ymod, ymod_next;

  gda_pkg::div_req_t          div_req;
  gda_pkg::div_rsp_t          div_rsp;
  logic signed [YW-1:0]       div_value;

  logic                 accept;
  logic [3:0]           mfix;
  logic [4:0]           dfix;
  logic signed [YW-1:0] y_in_ext;
  logic signed [YW-1:0] n_ext;
  logic signed [DW-1:0] n_day;
  logic signed [DW-1:0] dfix_ext;
  logic signed [YW-1:0] mfix_ext;
  logic signed [YW-1:0] y_start;
  logic signed [YW-1:0] month_idx;

  logic [4:0]           md_now;
  logic signed [DW-1:0] md_now_ext;
  logic                 wrap_fwd;
  logic [3:0]           m_fwd;
  logic signed [YW-1:0] y_fwd;
  logic [RW-1:0]        ymod_fwd;
  logic                 wrap_bk;
  logic [3:0]           m_bk;
  logic signed [YW-1:0] y_bk;
  logic [RW-1:0]        ymod_bk;
  logic [4:0]           md_bk;
  logic signed [DW-1:0] md_bk_ext;
  logic                 in_range;

  assign busy   = (state != gda_pkg::S_IDLE);
  assign accept = start && !busy;

  // Out-of-range month and day fields are pulled to the nearest legal value.
  assign mfix = (month_in == 4'd0) ? gda_pkg::MONTH_FIRST :
                (month_in > gda_pkg::MONTH_LAST) ? gda_pkg::MONTH_LAST : month_in;
  assign dfix = (day_in == 5'd0) ? 5'd1 : day_in;

  assign y_in_ext  = {{(YW-16){year_in[15]}}, year_in};
  assign n_ext     = {{(YW-AB){amount[AB-1]}}, amount};
  assign n_day     = {{(DW-AB){amount[AB-1]}}, amount};
  assign dfix_ext  = $signed({{(DW-5){1'b0}}, dfix});
  assign mfix_ext  = $signed({{(YW-4){1'b0}}, mfix});
  assign y_start   = (command == gda_pkg::CMD_YEARS) ? (y_in_ext + n_ext) : y_in_ext;
  // Zero-based month count from the start of the year, before the split by 12.
  assign month_idx = mfix_ext - YW'(1) + n_ext;

  assign md_now     = gda_pkg::days_in_month(month, gda_pkg::is_leap(ymod, year[1:0]));
  assign md_now_ext = $signed({{(DW-5){1'b0}}, md_now});

  assign wrap_fwd = (month == gda_pkg::MONTH_LAST);
  assign m_fwd    = wrap_fwd ? gda_pkg::MONTH_FIRST : (month + 4'd1);
  assign y_fwd    = wrap_fwd ? (year + YW'(1)) : year;
  assign ymod_fwd = !wrap_fwd ? ymod :
                    (ymod == gda_pkg::YMOD_MAX) ? '0 : (ymod + RW'(1));

  assign wrap_bk   = (month == gda_pkg::MONTH_FIRST);
  assign m_bk      = wrap_bk ? gda_pkg::MONTH_LAST : (month - 4'd1);
  assign y_bk      = wrap_bk ? (year - YW'(1)) : year;
  assign ymod_bk   = !wrap_bk ? ymod :
                     (ymod == '0) ? gda_pkg::YMOD_MAX : (ymod - RW'(1));
  assign md_bk     = gda_pkg::days_in_month(m_bk, gda_pkg::is_leap(ymod_bk, y_bk[1:0]));
  assign md_bk_ext = $signed({{(DW-5){1'b0}}, md_bk});

  assign in_range = (&year[YW-1:15]) || !(|year[YW-1:15]);

  always_comb begin
    div_req.start = 1'b0;
    div_req.sel   = gda_pkg::DIV_BY_400;
    div_value     = year;
    if (state == gda_pkg::S_IDLE) begin
      div_req.start = accept && (amount != '0) && (command != gda_pkg::CMD_NONE);
      if (command == gda_pkg::CMD_MONTHS) begin
        div_req.sel = gda_pkg::DIV_BY_12;
        div_value   = month_idx;
      end else begin
        div_value   = y_start;
      end
    end else if (state == gda_pkg::S_MODGO) begin
      div_req.start = 1'b1;
    end
  end

  gda_cdiv u_cdiv (
    .clk   (clk),
    .rst   (rst),
    .req   (div_req),
    .value (div_value),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_next = state;
    cmd_next   = cmd;
    neg_next   = neg;
    clamp_next = clamp;
    year_next  = year;
    month_next = month;
    day_next   = day;
    ymod_next  = ymod;
    case (state)
      gda_pkg::S_IDLE: begin
        if (accept) begin
          cmd_next   = gda_pkg::cmd_t'(command);
          neg_next   = amount[AB-1];
          year_next  = y_start;
          month_next = mfix;
          day_next   = (command == gda_pkg::CMD_DAYS) ? (dfix_ext + n_day) : dfix_ext;
          if (amount == '0 || command == gda_pkg::CMD_NONE) begin
            clamp_next = 1'b0;
            year_next  = y_in_ext;
            day_next   = dfix_ext;
            state_next = gda_pkg::S_DONE;
          end else begin
            clamp_next = (command != gda_pkg::CMD_DAYS);
            state_next = (command == gda_pkg::CMD_MONTHS) ? gda_pkg::S_QDIV
                                                          : gda_pkg::S_MOD;
          end
        end
      end
      gda_pkg::S_QDIV: begin
        if (div_rsp.done) begin
          month_next = div_rsp.rem[3:0] + 4'd1;
          year_next  = year + div_rsp.quo;
          state_next = gda_pkg::S_MODGO;
        end
      end
      gda_pkg::S_MODGO: begin
        state_next = gda_pkg::S_MOD;
      end
      gda_pkg::S_MOD: begin
        if (div_rsp.done) begin
          ymod_next  = div_rsp.rem;
          state_next = (cmd == gda_pkg::CMD_DAYS) ? gda_pkg::S_CENT : gda_pkg::S_DONE;
        end
      end
      gda_pkg::S_CENT: begin
        // Whole 400-year cycles are skipped before the month walk.
        if (!neg && day > gda_pkg::CENT_LIMIT) begin
          day_next  = day - gda_pkg::DAYS_400;
          year_next = year + gda_pkg::YEARS_400;
        end else if (neg && day < -gda_pkg::DAYS_400) begin
          day_next  = day + gda_pkg::DAYS_400;
          year_next = year - gda_pkg::YEARS_400;
        end else begin
          state_next = gda_pkg::S_WALK;
        end
      end
      gda_pkg::S_WALK: begin
        if (!neg && day > md_now_ext) begin
          day_next   = day - md_now_ext;
          month_next = m_fwd;
          year_next  = y_fwd;
          ymod_next  = ymod_fwd;
        end else if (neg && day < DW'(1)) begin
          day_next   = day + md_bk_ext;
          month_next = m_bk;
          year_next  = y_bk;
          ymod_next  = ymod_bk;
        end else begin
          state_next = gda_pkg::S_DONE;
        end
      end
      gda_pkg::S_DONE: begin
        state_next = gda_pkg::S_IDLE;
      end
      default: begin
        state_next = gda_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gda_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd   <= cmd_next;
    neg   <= neg_next;
    clamp <= clamp_next;
    year  <= year_next;
    month <= month_next;
    day   <= day_next;
    ymod  <= ymod_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == gda_pkg::S_DONE);
    end
  end

  // Month and year steps clamp the day to the length of the target month.
  always_ff @(posedge clk) begin
    if (state == gda_pkg::S_DONE) begin
      year_out      <= year[15:0];
      month_out     <= month;
      day_out       <= (clamp && day > md_now_ext) ? md_now : day[4:0];
      year_overflow <= !in_range;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("Result strobe raised while the sequencer is still busy.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("Accepted word did not make the block busy.");

  a_result_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (month_out >= 4'd1 && month_out <= 4'd12 &&
              day_out >= 5'd1 && day_out <= 5'd31))
    else $error("Result date has an illegal month or day.");

  a_ymod_range: assert property (@(posedge clk) disable iff (rst)
    (state == gda_pkg::S_WALK) |-> (ymod <= gda_pkg::YMOD_MAX))
    else $error("Year modulo 400 left its range during the month walk.");

  a_walk_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == gda_pkg::S_DONE) |=> done)
    else $error("Finished item did not raise the result strobe.");

endmodule

`default_nettype wire

>>> hw/rtl/gda_cdiv.sv
// ----------------------------------------------------------------------------
// gda_cdiv
// Floor division of a signed year-wide value by 12 or by 400 in three stages
// by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module gda_cdiv (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire gda_pkg::div_req_t              req,
  input  wire logic signed [gda_pkg::YW-1:0]  value,
  output gda_pkg::div_rsp_t                   rsp
);

  localparam int YW = gda_pkg::YW;
  localparam int RW = gda_pkg::REM_W;

  logic [YW-1:0]        mag;
  logic                 neg;
  gda_pkg::div_sel_t    sel;
  logic [YW-1:0]        qmag;
  logic                 mag_valid;
  logic                 quo_valid;
  logic                 done;
  logic signed [YW-1:0] quo;
  logic [RW-1:0]        rem;

  logic [gda_pkg::Q3_W-1:0]  x3;
  logic [gda_pkg::Q25_W-1:0] x25;
  logic [gda_pkg::P3_W-1:0]  p3;
  logic [gda_pkg::P25_W-1:0] p25;
  logic [YW-1:0]             q_calc;
  logic [RW-1:0]             divisor;
  logic [2*RW-1:0]           prod;
  logic [RW-1:0]             rem_mag;
  logic [RW-1:0]             rem_neg;

  // Dividing by 12 is dividing by 4 and then by 3; by 400 is by 16 and then 25.
  assign x3  = mag[YW-2:2];
  assign x25 = mag[YW-2:4];
  assign p3  = x3 * gda_pkg::RECIP_3;
  assign p25 = x25 * gda_pkg::RECIP_25;
  assign q_calc = (sel == gda_pkg::DIV_BY_400)
    ? {{(YW - gda_pkg::Q25_W + 4){1'b0}}, p25[gda_pkg::P25_W-1:gda_pkg::K25]}
    : {{(YW - gda_pkg::Q3_W + 1){1'b0}}, p3[gda_pkg::P3_W-1:gda_pkg::K3]};

  // The remainder is below 400, so the low bits of the difference suffice.
  assign divisor = (sel == gda_pkg::DIV_BY_400) ? gda_pkg::DIVISOR_400
                                                : gda_pkg::DIVISOR_12;
  assign prod    = qmag[RW-1:0] * divisor;
  assign rem_mag = mag[RW-1:0] - prod[RW-1:0];
  assign rem_neg = divisor - RW'(1) - rem_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
      quo_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      mag_valid <= req.start;
      quo_valid <= mag_valid;
      done      <= quo_valid;
    end
  end

  // A negative value v is divided as ~v = -v-1; the floor quotient is then
  // ~q and the true modulus is divisor-1-r.
  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= value[YW-1];
      mag <= value[YW-1] ? ~value : value;
      sel <= req.sel;
    end
    if (mag_valid) begin
      qmag <= q_calc;
    end
    if (quo_valid) begin
      quo <= neg ? $signed(~qmag) : $signed(qmag);
      rem <= neg ? rem_neg : rem_mag;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire
